>>> rtl/hsc_pkg.sv
// ---------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and helper functions for the variable-length
// Hamming single-error-correcting encoder/decoder.
// ---------------------------------------------------------------------------
package hsc_pkg;

  // Code geometry
  localparam int MAX_CODE_BITS = 64;
  localparam int DATA_W        = 57;
  localparam int LEN_W         = 6;   // data_length register width
  localparam int POS_W         = 7;   // code position / syndrome width
  localparam int SYN_BITS      = 7;   // parity masks needed for positions 1..64
  localparam int SHIFT_W       = 6;   // bit index into the code word

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DATA_LENGTH = REG_IDX_W'(0);
  localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = LEN_W'(4);

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [DATA_W-1:0]        data_word;
    logic [MAX_CODE_BITS-1:0] code_word;
  } hsc_in_t;

  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] code_out;
    logic [POS_W-1:0]         error_position;
    logic                     syndrome_out_of_range;
  } hsc_out_t;

  // Least r with 2^r >= m + r + 1
  function automatic logic [POS_W-1:0] parity_count(input logic [POS_W-1:0] m);
    logic [POS_W-1:0] r;
    r = '0;
    for (int j = 0; j < POS_W; j++) begin
      if ((POS_W'(1) << r) < POS_W'(m + r + POS_W'(1)) || (r < POS_W'(POS_W - 1) &&
          (8'(1) << r) < 8'(m) + 8'(r) + 8'd1)) begin
        r = r + POS_W'(1);
      end
    end
    return r;
  endfunction

  // Largest data length whose code still fits in MAX_CODE_BITS
  function automatic int max_data_bits();
    int best;
    best = 0;
    for (int m = 0; m <= MAX_CODE_BITS; m++) begin
      if (m + int'(parity_count(POS_W'(m))) <= MAX_CODE_BITS) begin
        best = m;
      end
    end
    return best;
  endfunction

  localparam int MAX_DATA_BITS = max_data_bits();

  // Code length n for a data_length register value (oversized values clamp)
  function automatic logic [POS_W-1:0] code_length(input logic [LEN_W-1:0] len);
    logic [POS_W-1:0] m;
    m = (int'(len) > MAX_DATA_BITS) ? POS_W'(MAX_DATA_BITS) : POS_W'(len);
    return POS_W'(m + parity_count(m));
  endfunction

  // Data bit index carried by code position k (k not a power of two):
  // skip the lg+1 parity positions 1, 2, 4, .. 2^lg that lie below k
  function automatic int data_index(input int k);
    int lg;
    lg = 0;
    for (int b = 0; b < POS_W; b++) begin
      if ((k >> b) != 0) begin
        lg = b;
      end
    end
    return k - 2 - lg;
  endfunction

  // Positions 1..MAX_CODE_BITS whose index has bit i set
  function automatic logic [MAX_CODE_BITS-1:0] check_mask(input int i);
    logic [MAX_CODE_BITS-1:0] mask;
    mask = '0;
    for (int k = 1; k <= MAX_CODE_BITS; k++) begin
      mask[k-1] = ((k >> i) & 1) != 0;
    end
    return mask;
  endfunction

endpackage

>>> rtl/hamming_sec_encode_decode_top.sv
// ---------------------------------------------------------------------------
// hamming_sec_encode_decode_top
// Variable-length Hamming SEC encoder/decoder with an APB-style register
// for the data length.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+---------------------------
//   in        | input     | in_valid/in_ready   | in_data  (hsc_in_t)
//   out       | output    | out_valid/out_ready | out_data (hsc_out_t)
//   apb       | input     | psel/penable/pready | paddr, pwdata, prdata
//
// Each accepted item passes through an input register, then the codec XOR
// trees into the result register. One item per clock is sustained while out
// is not stalled; the input register keeps filling while a result waits.
// Reset clears both valid flags and loads data_length = 4.
// A stall on out holds the result; in_ready drops only when both registers
// are full and out is stalled.
// ---------------------------------------------------------------------------
module hamming_sec_encode_decode_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hsc_pkg::hsc_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hsc_pkg::hsc_out_t                out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import hsc_pkg::*;

  logic [LEN_W-1:0]      data_length;
  logic [POS_W-1:0]      code_len;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_write;
  hsc_in_t               in_reg;
  logic                  in_full;
  logic                  advance;
  hsc_out_t              result_next;

  // Register access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && (reg_idx == REG_DATA_LENGTH);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DATA_LENGTH) begin
      prdata = APB_DATA_W'(data_length);
    end
  end

  // Hold the length register and its derived code length
  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= DATA_LENGTH_RESET;
      code_len    <= code_length(DATA_LENGTH_RESET);
    end else if (cfg_write) begin
      data_length <= pwdata[LEN_W-1:0];
      code_len    <= code_length(pwdata[LEN_W-1:0]);
    end
  end

  // Pipeline flow control
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  hsc_codec u_codec (
    .item     (in_reg),
    .code_len (code_len),
    .result   (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

endmodule

>>> rtl/hsc_codec.sv
// ---------------------------------------------------------------------------
// hsc_codec
// Single-pass Hamming encode / check-and-correct datapath. Data bits are
// wired to their fixed code positions, one XOR tree per syndrome bit serves
// both the parity of an encode and the syndrome of a decode.
// ---------------------------------------------------------------------------
module hsc_codec (
  input  hsc_pkg::hsc_in_t             item,
  input  logic [hsc_pkg::POS_W-1:0]    code_len,
  output hsc_pkg::hsc_out_t            result
);
  import hsc_pkg::*;

  logic [MAX_CODE_BITS-1:0] pos_valid;
  logic [MAX_CODE_BITS-1:0] spread;
  logic [MAX_CODE_BITS-1:0] checked;
  logic [MAX_CODE_BITS-1:0] parity_bits;
  logic [MAX_CODE_BITS-1:0] flip_bit;
  logic [POS_W-1:0]         syn;
  logic                     syn_high;

  // Mark positions inside the code and spread data bits onto their positions
  always_comb begin
    pos_valid = '0;
    spread    = '0;
    for (int k = 1; k <= MAX_CODE_BITS; k++) begin
      pos_valid[k-1] = (POS_W'(k) <= code_len);
      if ((k & (k - 1)) != 0) begin
        spread[k-1] = item.data_word[data_index(k)];
      end
    end
  end

  // Select the word whose syndrome is taken, then build the syndrome
  always_comb begin
    checked = ((item.op == OP_ENCODE) ? spread : item.code_word) & pos_valid;
    for (int i = 0; i < SYN_BITS; i++) begin
      syn[i] = ^(checked & check_mask(i));
    end
  end

  // Parity bits for encode, single-bit flip for decode
  always_comb begin
    parity_bits = '0;
    for (int i = 0; i < SYN_BITS; i++) begin
      parity_bits[(1 << i) - 1] = syn[i];
    end
    syn_high = (syn > code_len);
    flip_bit = '0;
    if (syn != '0 && !syn_high) begin
      flip_bit = MAX_CODE_BITS'(1) << SHIFT_W'(syn - POS_W'(1));
    end
  end

  // Assemble the result
  always_comb begin
    if (item.op == OP_ENCODE) begin
      result.code_out              = (checked | parity_bits) & pos_valid;
      result.error_position        = '0;
      result.syndrome_out_of_range = 1'b0;
    end else begin
      result.code_out              = checked ^ flip_bit;
      result.error_position        = syn;
      result.syndrome_out_of_range = syn_high;
    end
  end

endmodule

>>> tb/sv/tb_hamming_sec_encode_decode_top.sv
// ----------------------------------------------------------------------------
// tb_hamming_sec_encode_decode_top
// Self-checking bench for the variable-length Hamming SEC codec. A directed
// table covers reset length, zero and clamped lengths, unused bits, single
// error correction and out-of-range syndromes. Random phases then run at
// several data lengths: valid code words with zero, one or two flipped bits,
// random encodes and noise. Each result is checked against its table row or
// an in-bench code model, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_hamming_sec_encode_decode_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 6;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 48;
  localparam int LONG_HOLD_AT     = 150;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PRINT_CAP        = 40;

  typedef struct {
    logic [LEN_W-1:0] len;
    hsc_in_t          stim;
    bit               typed;
    hsc_out_t         want;
  } vector_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  hsc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  hsc_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Data length the block is currently programmed with
  logic [LEN_W-1:0] cur_len = DATA_LENGTH_RESET;
  hsc_out_t         due_words[$];
  int               mismatches = 0;
  bit               sender_slow = 1'b0;

  hamming_sec_encode_decode_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Code model
  // --------------------------------------------------------------------------
  function automatic int parity_bits(input int m);
    int r;
    r = 0;
    while ((1 << r) < m + r + 1) r++;
    return r;
  endfunction

  // Code length n for a register value; oversized lengths shrink until they fit
  function automatic int code_length_of(input logic [LEN_W-1:0] len);
    int m;
    int r;
    m = int'(len);
    r = parity_bits(m);
    while (m > 0 && m + r > MAX_CODE_BITS) begin
      m--;
      r = parity_bits(m);
    end
    return m + r;
  endfunction

  function automatic logic [MAX_CODE_BITS-1:0] span_mask(input int n);
    if (n >= MAX_CODE_BITS) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic hsc_out_t hamming_codec(input hsc_in_t w, input logic [LEN_W-1:0] len);
    int                       n;
    int                       d;
    int                       syn;
    logic [MAX_CODE_BITS-1:0] word;
    hsc_out_t                 res;
    n    = code_length_of(len);
    d    = 0;
    syn  = 0;
    word = '0;
    res  = '0;
    if (w.op == OP_ENCODE) begin
      // place data bits on non-power-of-two positions, then fix parity
      for (int k = 1; k <= n; k++) begin
        if ((k & (k - 1)) != 0) begin
          if (w.data_word[d]) begin
            word[k-1] = 1'b1;
            syn ^= k;
          end
          d++;
        end
      end
      for (int i = 0; (1 << i) <= n; i++) begin
        if (syn[i]) word[(1 << i) - 1] = 1'b1;
      end
    end else begin
      // syndrome is the XOR of all set positions; flip only inside the code
      word = w.code_word & span_mask(n);
      for (int k = 1; k <= n; k++) begin
        if (word[k-1]) syn ^= k;
      end
      if (syn != 0 && syn <= n) word[syn-1] = ~word[syn-1];
      res.error_position        = POS_W'(syn);
      res.syndrome_out_of_range = (syn > n);
    end
    res.code_out = word;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic vector_t row(input logic [LEN_W-1:0] len, input logic op,
                                  input logic [DATA_W-1:0] data,
                                  input logic [MAX_CODE_BITS-1:0] code, input bit typed,
                                  input logic [MAX_CODE_BITS-1:0] code_out,
                                  input logic [POS_W-1:0] pos, input logic range_flag);
    vector_t v;
    v.len                        = len;
    v.stim.op                    = op;
    v.stim.data_word             = data;
    v.stim.code_word             = code;
    v.typed                      = typed;
    v.want.code_out              = code_out;
    v.want.error_position        = pos;
    v.want.syndrome_out_of_range = range_flag;
    return v;
  endfunction

  // Valid code words, mostly corrupted, plus encodes and some raw noise
  function automatic hsc_in_t random_word(input logic [LEN_W-1:0] len);
    hsc_in_t                  w;
    hsc_out_t                 enc;
    logic [MAX_CODE_BITS-1:0] code;
    int                       n;
    int                       sel;
    int                       p;
    n           = code_length_of(len);
    w.op        = OP_ENCODE;
    w.data_word = DATA_W'(rand64());
    w.code_word = rand64();
    sel         = $urandom_range(0, 19);
    if (sel < 8) return w;
    if (sel < 17) begin
      enc  = hamming_codec(w, len);
      code = enc.code_out;
      case ($urandom_range(0, 3))
        1, 2: begin
          if (n > 0) begin
            p       = $urandom_range(0, n - 1);
            code[p] = ~code[p];
          end
        end
        3: begin
          if (n > 0) begin
            p       = $urandom_range(0, n - 1);
            code[p] = ~code[p];
            p       = $urandom_range(0, n - 1);
            code[p] = ~code[p];
          end
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) code |= rand64() & ~span_mask(n);
      w.code_word = code;
    end
    w.op = OP_DECODE;
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s mismatch: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Present one word after a random gap and hold it until the transfer
  task automatic offer_word(input hsc_in_t w, input bit typed, input hsc_out_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) sender_slow = !sender_slow;
    gap = sender_slow ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    due_words.push_back(typed ? want : hamming_codec(w, cur_len));
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(REG_DATA_LENGTH) << 2;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_len = value;
  endtask

  task automatic reg_read_check();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(REG_DATA_LENGTH) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(cur_len))
      flag_mismatch("data_length readback", 64'(prdata), 64'(cur_len));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    vector_t          directed[$];
    logic [LEN_W-1:0] phase_len;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset value of the length register
    reg_read_check();

    // default length 4: n = 7, a perfect code
    directed.push_back(row(4, OP_ENCODE, '0, '0, 1, 64'h0, 0, 0));
    directed.push_back(row(4, OP_ENCODE, 57'hF, '0, 1, 64'h7F, 0, 0));
    directed.push_back(row(4, OP_ENCODE, '1, '0, 1, 64'h7F, 0, 0));
    directed.push_back(row(4, OP_DECODE, '0, 64'h7F, 1, 64'h7F, 0, 0));
    directed.push_back(row(4, OP_DECODE, '0, 64'h7B, 1, 64'h7F, 3, 0));
    directed.push_back(row(4, OP_DECODE, '0, 64'h7E, 1, 64'h7F, 1, 0));
    directed.push_back(row(4, OP_DECODE, '0, 64'hFFFF_FFFF_FFFF_FF80, 1, 64'h0, 0, 0));
    directed.push_back(row(4, OP_ENCODE, 57'h5, '0, 0, '0, 0, 0));
    // zero length: nothing in, nothing out
    directed.push_back(row(0, OP_ENCODE, '1, '1, 1, 64'h0, 0, 0));
    directed.push_back(row(0, OP_DECODE, '1, '1, 1, 64'h0, 0, 0));
    // one data bit
    directed.push_back(row(1, OP_ENCODE, 57'h1, '0, 1, 64'h7, 0, 0));
    directed.push_back(row(1, OP_DECODE, '0, 64'h5, 1, 64'h7, 2, 0));
    // two data bits, n = 5: syndrome 7 lies past the code
    directed.push_back(row(2, OP_DECODE, '0, 64'hC, 1, 64'hC, 7, 1));
    directed.push_back(row(2, OP_ENCODE, 57'h3, '0, 0, '0, 0, 0));
    directed.push_back(row(2, OP_DECODE, '0, '1, 0, '0, 0, 0));
    // n = 62: positions 1 and 62 give syndrome 63
    directed.push_back(row(56, OP_DECODE, '0, 64'h2000_0000_0000_0001, 1,
                           64'h2000_0000_0000_0001, 63, 1));
    // longest code, n = 63; top bit never belongs to the code
    directed.push_back(row(57, OP_ENCODE, '0, '0, 1, 64'h0, 0, 0));
    directed.push_back(row(57, OP_ENCODE, '1, '0, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
    directed.push_back(row(57, OP_DECODE, '0, '1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
    directed.push_back(row(57, OP_DECODE, '0, 64'h8000_0000_0000_0000, 1, 64'h0, 0, 0));
    directed.push_back(row(57, OP_ENCODE, 57'h0AA_AAAA_5555_5555, '0, 0, '0, 0, 0));
    // oversized lengths act as 57
    directed.push_back(row(63, OP_ENCODE, '1, '0, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
    directed.push_back(row(63, OP_DECODE, '0, '1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
    directed.push_back(row(58, OP_DECODE, '0, 64'h1, 1, 64'h0, 1, 0));

    foreach (directed[i]) begin
      if (directed[i].len != cur_len) begin
        wait_idle();
        reg_write(directed[i].len);
        reg_read_check();
      end
      offer_word(directed[i].stim, directed[i].typed, directed[i].want);
    end

    // random phases: extremes first, then arbitrary register values
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_len = 6'd57;
        1:       phase_len = 6'd0;
        2:       phase_len = 6'd63;
        3:       phase_len = 6'd1;
        default: phase_len = LEN_W'($urandom_range(0, 63));
      endcase
      wait_idle();
      reg_write(phase_len);
      reg_read_check();
      repeat (PHASE_ITEMS) offer_word(random_word(cur_len), 1'b0, '0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_hamming_sec_encode_decode_top passed");
    end else begin
      $display("tb_hamming_sec_encode_decode_top failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls, one long hold-off to back up the pipeline
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int taken;
    bit slow;
    taken = 0;
    slow  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) slow = !slow;
      stall = slow ? $urandom_range(0, 18) : 0;
      if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Compare each result transfer with the oldest expected word
  always @(posedge clk) begin : result_check
    hsc_out_t want;
    if (rst === 1'b0 && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        flag_mismatch("unexpected result, code_out", out_data.code_out, 64'h0);
      end else begin
        want = due_words.pop_front();
        if (out_data.code_out !== want.code_out)
          flag_mismatch("code_out", out_data.code_out, want.code_out);
        if (out_data.error_position !== want.error_position)
          flag_mismatch("error_position", 64'(out_data.error_position),
                        64'(want.error_position));
        if (out_data.syndrome_out_of_range !== want.syndrome_out_of_range)
          flag_mismatch("syndrome_out_of_range", 64'(out_data.syndrome_out_of_range),
                        64'(want.syndrome_out_of_range));
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || psel || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_hamming_sec_encode_decode_top failed");
    $finish;
  end

endmodule

>>> hamming_sec_encode_decode_top.f
rtl/hsc_pkg.sv
rtl/hsc_codec.sv
rtl/hamming_sec_encode_decode_top.sv
tb/sv/tb_hamming_sec_encode_decode_top.sv
